// ----- rtl/core/dmq_pkg.sv -----
// Shared constants and types for the base-q digitwise sum/difference block.
package dmq_pkg;

  localparam int unsigned NumDigits = 31;
  localparam int unsigned OpndW     = 31;
  localparam int unsigned CodeW     = 36;
  localparam int unsigned RadixW    = 5;
  localparam int unsigned RecipW    = 32;
  localparam int unsigned RadixNum  = 1 << RadixW;

  localparam logic [RadixW-1:0] RadixReset = RadixW'(2);
  localparam logic [RadixW-1:0] RadixMin   = RadixW'(2);

  // Per-word state carried from one digit stage to the next
  typedef struct packed {
    logic [OpndW-1:0]  a;
    logic [OpndW-1:0]  b;
    logic [CodeW-1:0]  sum;
    logic [CodeW-1:0]  dif;
    logic [CodeW-1:0]  wgt;
    logic [RadixW-1:0] ds;
    logic [RadixW-1:0] dd;
  } dmq_lane_t;

endpackage

// ----- rtl/core/dmq_if.sv -----
// Valid/ready channel interfaces for operand and result words.
interface dmq_in_if
  import dmq_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [OpndW-1:0] first_operator;
  logic [OpndW-1:0] second_operator;
  modport source (output valid, output first_operator, output second_operator, input ready);
  modport sink   (input valid, input first_operator, input second_operator, output ready);
endinterface

interface dmq_out_if
  import dmq_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [CodeW-1:0] digit_sum_code;
  logic [CodeW-1:0] digit_difference_code;
  modport source (output valid, output digit_sum_code, output digit_difference_code,
                  input ready);
  modport sink   (input valid, input digit_sum_code, input digit_difference_code,
                  output ready);
endinterface

// ----- rtl/core/digitwise_mod_q_sum_difference_top.sv -----
// Top level of the base-q digitwise modular sum/difference pipeline.
//
// Operand words arrive on in_i (first_operator, second_operator); each gives
// exactly one result word on out_o (digit_sum_code, digit_difference_code).
// The radix register is written through cfg_we_i/cfg_wdata_i; radix 0 and 1
// act as 2. Write it only while no word is in flight.
//
// One word is accepted per cycle while out_o is not stalled. From accept to
// the result being valid a word passes two register stages per digit position
// for 31 digit positions (reciprocal multiply, then remainder fix-up) and one
// output register that folds in the last digit.
//
// Reset clears all valid bits and sets the radix to 2. When the receiver
// holds out_o.ready low with a word waiting, the whole pipeline freezes and
// in_i.ready drops in the same cycle; nothing is lost or repeated.
module digitwise_mod_q_sum_difference_top
  import dmq_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [RadixW-1:0] cfg_wdata_i,
  dmq_in_if.sink            in_i,
  dmq_out_if.source         out_o
);

  // Radix register and effective radix
  logic [RadixW-1:0] radix_q, q_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q <= RadixReset;
    end else if (cfg_we_i) begin
      radix_q <= cfg_wdata_i;
    end
  end

  assign q_eff = (radix_q < RadixMin) ? RadixMin : radix_q;

  // Reciprocal table floor(2^32 / q)
  logic [RecipW-1:0] recip_tab [RadixNum];
  logic [RecipW-1:0] recip;

  for (genvar gi = 0; gi < RadixNum; gi++) begin : g_recip
    if (gi < 2) begin : g_low
      assign recip_tab[gi] = '0;
    end else begin : g_val
      localparam logic [RecipW:0] Recip = (RecipW+1)'((64'd1 << RecipW) / gi);
      assign recip_tab[gi] = Recip[RecipW-1:0];
    end
  end

  assign recip = recip_tab[q_eff];

  // Global advance: move unless a result waits on a stalled receiver
  logic en;
  assign en         = !out_o.valid || out_o.ready;
  assign in_i.ready = en;

  // Digit stage chain
  logic      valid_s [NumDigits+1];
  dmq_lane_t lane_s  [NumDigits+1];

  assign valid_s[0]    = in_i.valid;
  assign lane_s[0].a   = in_i.first_operator;
  assign lane_s[0].b   = in_i.second_operator;
  assign lane_s[0].sum = '0;
  assign lane_s[0].dif = '0;
  assign lane_s[0].wgt = CodeW'(1);
  assign lane_s[0].ds  = '0;
  assign lane_s[0].dd  = '0;

  for (genvar gd = 0; gd < NumDigits; gd++) begin : g_digit
    dmq_digit_stage u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .first_i (gd == 0),
      .q_i     (q_eff),
      .recip_i (recip),
      .valid_i (valid_s[gd]),
      .lane_i  (lane_s[gd]),
      .valid_o (valid_s[gd+1]),
      .lane_o  (lane_s[gd+1])
    );
  end

  // Output register: fold in the last digit
  logic             out_valid_q;
  logic [CodeW-1:0] sum_out_q, dif_out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= valid_s[NumDigits];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sum_out_q <= lane_s[NumDigits].sum
                   + CodeW'(lane_s[NumDigits].ds) * lane_s[NumDigits].wgt;
      dif_out_q <= lane_s[NumDigits].dif
                   + CodeW'(lane_s[NumDigits].dd) * lane_s[NumDigits].wgt;
    end
  end

  assign out_o.valid                 = out_valid_q;
  assign out_o.digit_sum_code        = sum_out_q;
  assign out_o.digit_difference_code = dif_out_q;

endmodule

// ----- rtl/core/dmq_digit_stage.sv -----
// One digit position: reciprocal divide, remainder fix-up and digit sum/difference.
module dmq_digit_stage
  import dmq_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              first_i,
  input  logic [RadixW-1:0] q_i,
  input  logic [RecipW-1:0] recip_i,
  input  logic              valid_i,
  input  dmq_lane_t         lane_i,
  output logic              valid_o,
  output dmq_lane_t         lane_o
);

  // Stage A: fold previous digit into the codes, estimate quotients
  // lane_i.wgt is the weight of lane_i.ds; wgt_d is the weight of this digit
  logic [OpndW+RecipW-1:0] prod_a, prod_b;
  logic [CodeW-1:0]        sum_d, dif_d, wgt_d;
  logic                    va_q;
  logic [OpndW-1:0]        a_q, b_q, qa_q, qb_q;
  logic [CodeW-1:0]        sum_q, dif_q, wgt_q;

  assign prod_a = (OpndW+RecipW)'(lane_i.a) * (OpndW+RecipW)'(recip_i);
  assign prod_b = (OpndW+RecipW)'(lane_i.b) * (OpndW+RecipW)'(recip_i);
  assign sum_d  = lane_i.sum + CodeW'(lane_i.ds) * lane_i.wgt;
  assign dif_d  = lane_i.dif + CodeW'(lane_i.dd) * lane_i.wgt;
  // lowest digit position has weight one
  assign wgt_d  = first_i ? CodeW'(1) : lane_i.wgt * CodeW'(q_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
    end else if (en_i) begin
      va_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_q   <= lane_i.a;
      b_q   <= lane_i.b;
      qa_q  <= prod_a[RecipW +: OpndW];
      qb_q  <= prod_b[RecipW +: OpndW];
      sum_q <= sum_d;
      dif_q <= dif_d;
      wgt_q <= wgt_d;
    end
  end

  // Stage B: estimate is exact or one low; correct and take the digits
  logic [OpndW-1:0]  ra, rb, qa_fix, qb_fix;
  logic [RadixW-1:0] da, db;
  logic [RadixW:0]   dsum;
  logic [RadixW-1:0] ds, dd;

  always_comb begin
    ra     = a_q - qa_q * OpndW'(q_i);
    rb     = b_q - qb_q * OpndW'(q_i);
    qa_fix = qa_q;
    qb_fix = qb_q;
    if (ra >= OpndW'(q_i)) begin
      ra     = ra - OpndW'(q_i);
      qa_fix = qa_q + OpndW'(1);
    end
    if (rb >= OpndW'(q_i)) begin
      rb     = rb - OpndW'(q_i);
      qb_fix = qb_q + OpndW'(1);
    end
    da   = ra[RadixW-1:0];
    db   = rb[RadixW-1:0];
    dsum = {1'b0, da} + {1'b0, db};
    if (dsum >= {1'b0, q_i}) begin
      ds = RadixW'(dsum - {1'b0, q_i});
    end else begin
      ds = dsum[RadixW-1:0];
    end
    if (da >= db) begin
      dd = da - db;
    end else begin
      dd = RadixW'({1'b0, da} + {1'b0, q_i} - {1'b0, db});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lane_o.a   <= qa_fix;
      lane_o.b   <= qb_fix;
      lane_o.sum <= sum_q;
      lane_o.dif <= dif_q;
      lane_o.wgt <= wgt_q;
      lane_o.ds  <= ds;
      lane_o.dd  <= dd;
    end
  end

endmodule

// ----- rtl/core/dmq_checker.sv -----
// Port-level checks for the digitwise sum/difference top level, with bind.
module dmq_checker
  import dmq_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic [CodeW-1:0] out_sum
);

  // Stalled result word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_sum)))
    else $error("result word changed while stalled");

  // Pipeline frozen by a stalled result refuses input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && !out_ready) |-> !in_ready)
    else $error("input taken while output stalled");

  // Free output always lets input through
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid || out_ready) |-> in_ready)
    else $error("input blocked without output stall");

  // No result word right after reset
  assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind digitwise_mod_q_sum_difference_top dmq_checker u_dmq_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_ready  (in_i.ready),
  .out_valid (out_o.valid),
  .out_ready (out_o.ready),
  .out_sum   (out_o.digit_sum_code)
);
